[hdl/kalman_angle_bias_filter_core_macros.svh]
// Assertion macros shared by the filter core.
`ifndef KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KABF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define KABF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/kabf_pkg.sv]
package kabf_pkg;

  localparam int unsigned DW = 48;
  localparam int unsigned CW = 32;

  localparam logic signed [DW-1:0] MAX48 = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN48 = {1'b1, {(DW-1){1'b0}}};

  localparam logic [CW-1:0] RST_Q_ANGLE = 32'd85899346;
  localparam logic [CW-1:0] RST_Q_BIAS  = 32'd12884902;
  localparam logic [CW-1:0] RST_R_MEAS  = 32'd42949673;
  localparam logic [CW-1:0] RST_DT      = 32'd3865470;

  typedef enum logic [1:0] {
    REG_Q_ANGLE = 2'd0,
    REG_Q_BIAS  = 2'd1,
    REG_R_MEAS  = 2'd2,
    REG_DT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } op_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] res;
  } op_rsp_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_ITER,
    DV_ROUND
  } div_st_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_P11DT,
    ST_TDT,
    ST_QB,
    ST_GAIN,
    ST_K0,
    ST_K1,
    ST_AY,
    ST_BY,
    ST_P10,
    ST_P00,
    ST_P11,
    ST_P01,
    ST_FIN
  } seq_st_t;

  // Magnitude of a signed word; the most negative value maps to 2^47.
  function automatic logic [DW-1:0] mag48(logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return m;
  endfunction

  // Apply a sign to a magnitude and saturate to the signed range.
  function automatic logic signed [DW-1:0] sat_mag(logic neg, logic [63:0] m);
    logic signed [DW-1:0] r;
    if (!neg) begin
      r = (m > 64'(MAX48)) ? MAX48 : $signed(m[DW-1:0]);
    end else begin
      r = (m > {16'd0, 1'b1, 47'd0}) ? MIN48 : $signed(-m[DW-1:0]);
    end
    return r;
  endfunction

  // Saturate a grown sum back to the signed range.
  function automatic logic signed [DW-1:0] sat48(logic signed [50:0] v);
    logic signed [DW-1:0] r;
    if (v > 51'(MAX48)) begin
      r = MAX48;
    end else if (v < 51'(MIN48)) begin
      r = MIN48;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/kabf_mul.sv]
// Rounded Q15.32 product over four partial products on one 32x32 multiplier.
module kabf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  kabf_pkg::op_req_t req,
  output kabf_pkg::op_rsp_t rsp
);

  logic [47:0] ma_r, mb_r;
  logic        neg_r;
  logic [2:0]  cnt_r;
  logic        busy_r;
  logic [63:0] prod_r, acc_r;
  logic [31:0] opx, opy;
  logic        done_r;
  logic signed [47:0] res_r;

  always_comb begin
    case (cnt_r)
      3'd1: begin
        opx = ma_r[31:0];
        opy = mb_r[31:0];
      end
      3'd2: begin
        opx = {16'd0, ma_r[47:32]};
        opy = mb_r[31:0];
      end
      3'd3: begin
        opx = ma_r[31:0];
        opy = {16'd0, mb_r[47:32]};
      end
      3'd4: begin
        opx = {16'd0, ma_r[47:32]};
        opy = {16'd0, mb_r[47:32]};
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= kabf_pkg::mag48(req.a);
      mb_r  <= kabf_pkg::mag48(req.b);
      neg_r <= req.a[47] ^ req.b[47];
    end
    prod_r <= opx * opy;
    case (cnt_r)
      3'd2: acc_r <= {32'd0, prod_r[63:32]} + {63'd0, prod_r[31]};
      3'd3, 3'd4: acc_r <= acc_r + prod_r;
      3'd5: res_r <= kabf_pkg::sat_mag(neg_r, acc_r + {prod_r[31:0], 32'd0});
      default: acc_r <= acc_r;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

[hdl/kabf_div.sv]
// Rounded Q15.32 quotient, one restoring step per cycle.
module kabf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kabf_pkg::op_req_t req,
  output kabf_pkg::op_rsp_t rsp
);

  kabf_pkg::div_st_t st_r, st_nxt;
  logic [47:0] mp_r, ms_r;
  logic        neg_r;
  logic [48:0] r_r;
  logic [46:0] d_r, q_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic signed [47:0] res_r;
  logic [48:0] r2;
  logic        ovf;
  logic [47:0] q_rnd;

  assign r2    = {r_r[47:0], d_r[46]};
  assign ovf   = {15'd0, mp_r} >= {ms_r, 15'd0};
  assign q_rnd = {1'b0, q_r} + {47'd0, ({r_r, 1'b0} >= {2'b00, ms_r})};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      kabf_pkg::DV_IDLE:  if (req.start) st_nxt = kabf_pkg::DV_CHECK;
      kabf_pkg::DV_CHECK: st_nxt = ovf ? kabf_pkg::DV_IDLE : kabf_pkg::DV_ITER;
      kabf_pkg::DV_ITER:  if (cnt_r == 6'd46) st_nxt = kabf_pkg::DV_ROUND;
      kabf_pkg::DV_ROUND: st_nxt = kabf_pkg::DV_IDLE;
      default:            st_nxt = kabf_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= kabf_pkg::DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= ((st_r == kabf_pkg::DV_CHECK) && ovf) || (st_r == kabf_pkg::DV_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      kabf_pkg::DV_IDLE: begin
        mp_r  <= kabf_pkg::mag48(req.a);
        ms_r  <= kabf_pkg::mag48(req.b);
        neg_r <= req.a[47] ^ req.b[47];
      end
      kabf_pkg::DV_CHECK: begin
        res_r <= neg_r ? kabf_pkg::MIN48 : kabf_pkg::MAX48;
        r_r   <= {16'd0, mp_r[47:15]};
        d_r   <= {mp_r[14:0], 32'd0};
        q_r   <= '0;
        cnt_r <= '0;
      end
      kabf_pkg::DV_ITER: begin
        if (r2 >= {1'b0, ms_r}) begin
          r_r <= r2 - {1'b0, ms_r};
          q_r <= {q_r[45:0], 1'b1};
        end else begin
          r_r <= r2;
          q_r <= {q_r[45:0], 1'b0};
        end
        d_r   <= {d_r[45:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
      end
      kabf_pkg::DV_ROUND: res_r <= kabf_pkg::sat_mag(neg_r, {16'd0, q_rnd});
      default: res_r <= res_r;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

[hdl/kalman_angle_bias_filter_core.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_gyro_rate, in_measured_angle (Q15.32)
// out_      output     out_valid / out_stall  out_filt_angle (Q15.32)
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// One beat runs from accept to accept: ten products on the shared multiplier, two quotients
// on the serial divider and the idle, gain and final sequencing states.
// A quotient that overflows ends after its check; a zero innovation covariance skips both.
// Reset is synchronous and active low; it restores the register defaults and clears the state.
// A finished result waits in the output register while the next beat is accepted; a new
// result waits in the last state until that register is free.
module kalman_angle_bias_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_gyro_rate,
  input  logic [47:0] in_measured_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_filt_angle,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

`include "kalman_angle_bias_filter_core_macros.svh"

  // Configuration registers.
  logic [31:0] q_angle_r, q_bias_r, r_meas_r, dt_r;

  // Filter state and the working values of one update.
  logic signed [47:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [47:0] meas_r, diff_r, t_r, s_r, y_r, k0_r, k1_r;
  logic signed [47:0] fused_r;
  logic               out_valid_r;

  kabf_pkg::seq_st_t st_r, st_nxt;
  logic go_r;

  kabf_pkg::op_req_t mul_req, div_req;
  kabf_pkg::op_rsp_t mul_rsp, div_rsp;

  logic accept;
  logic fin_load;
  logic signed [47:0] dt_s, s_nxt;
  logic signed [50:0] t_sum;

  assign accept   = in_valid && (st_r == kabf_pkg::ST_IDLE);
  assign in_stall = (st_r != kabf_pkg::ST_IDLE);
  assign fin_load = (st_r == kabf_pkg::ST_FIN) && (!out_valid_r || !out_stall);
  assign dt_s     = {16'd0, dt_r};
  assign s_nxt    = kabf_pkg::sat48(51'(p00_r) + {19'd0, r_meas_r});

  // The angle increment term is summed exactly and saturated once.
  assign t_sum = 51'(mul_rsp.res) - 51'(p01_r) - 51'(p10_r) + {19'd0, q_angle_r};

  kabf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Operand selection for the shared units follows the sequencer state.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (st_r)
      kabf_pkg::ST_RATE:  begin mul_req.a = diff_r;               mul_req.b = dt_s;  end
      kabf_pkg::ST_P11DT: begin mul_req.a = p11_r;                mul_req.b = dt_s;  end
      kabf_pkg::ST_TDT:   begin mul_req.a = t_r;                  mul_req.b = dt_s;  end
      kabf_pkg::ST_QB:    begin mul_req.a = {16'd0, q_bias_r};    mul_req.b = dt_s;  end
      kabf_pkg::ST_AY:    begin mul_req.a = k0_r;                 mul_req.b = y_r;   end
      kabf_pkg::ST_BY:    begin mul_req.a = k1_r;                 mul_req.b = y_r;   end
      kabf_pkg::ST_P10:   begin mul_req.a = k1_r;                 mul_req.b = p00_r; end
      kabf_pkg::ST_P00:   begin mul_req.a = k0_r;                 mul_req.b = p00_r; end
      kabf_pkg::ST_P11:   begin mul_req.a = k1_r;                 mul_req.b = p01_r; end
      kabf_pkg::ST_P01:   begin mul_req.a = k0_r;                 mul_req.b = p01_r; end
      kabf_pkg::ST_K0:    begin div_req.a = p00_r;                div_req.b = s_r;   end
      kabf_pkg::ST_K1:    begin div_req.a = p10_r;                div_req.b = s_r;   end
      default:            mul_req = '0;
    endcase
    div_req.start = go_r && ((st_r == kabf_pkg::ST_K0) || (st_r == kabf_pkg::ST_K1));
    mul_req.start = go_r && (st_r != kabf_pkg::ST_K0) && (st_r != kabf_pkg::ST_K1) &&
                    (st_r != kabf_pkg::ST_IDLE) && (st_r != kabf_pkg::ST_GAIN) &&
                    (st_r != kabf_pkg::ST_FIN);
  end

  // Next state: each arithmetic state waits for its unit, then moves on.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      kabf_pkg::ST_IDLE:  if (accept) st_nxt = kabf_pkg::ST_RATE;
      kabf_pkg::ST_RATE:  if (mul_rsp.done) st_nxt = kabf_pkg::ST_P11DT;
      kabf_pkg::ST_P11DT: if (mul_rsp.done) st_nxt = kabf_pkg::ST_TDT;
      kabf_pkg::ST_TDT:   if (mul_rsp.done) st_nxt = kabf_pkg::ST_QB;
      kabf_pkg::ST_QB:    if (mul_rsp.done) st_nxt = kabf_pkg::ST_GAIN;
      kabf_pkg::ST_GAIN:  st_nxt = (s_nxt == '0) ? kabf_pkg::ST_AY : kabf_pkg::ST_K0;
      kabf_pkg::ST_K0:    if (div_rsp.done) st_nxt = kabf_pkg::ST_K1;
      kabf_pkg::ST_K1:    if (div_rsp.done) st_nxt = kabf_pkg::ST_AY;
      kabf_pkg::ST_AY:    if (mul_rsp.done) st_nxt = kabf_pkg::ST_BY;
      kabf_pkg::ST_BY:    if (mul_rsp.done) st_nxt = kabf_pkg::ST_P10;
      kabf_pkg::ST_P10:   if (mul_rsp.done) st_nxt = kabf_pkg::ST_P00;
      kabf_pkg::ST_P00:   if (mul_rsp.done) st_nxt = kabf_pkg::ST_P11;
      kabf_pkg::ST_P11:   if (mul_rsp.done) st_nxt = kabf_pkg::ST_P01;
      kabf_pkg::ST_P01:   if (mul_rsp.done) st_nxt = kabf_pkg::ST_FIN;
      kabf_pkg::ST_FIN:   if (fin_load) st_nxt = kabf_pkg::ST_IDLE;
      default:            st_nxt = kabf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= kabf_pkg::ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      q_angle_r   <= kabf_pkg::RST_Q_ANGLE;
      q_bias_r    <= kabf_pkg::RST_Q_BIAS;
      r_meas_r    <= kabf_pkg::RST_R_MEAS;
      dt_r        <= kabf_pkg::RST_DT;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= '0;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= '0;
    end else begin
      st_r <= st_nxt;
      // A start pulse goes out on the first cycle of each arithmetic state.
      go_r <= (st_nxt != st_r);
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (kabf_pkg::cfg_reg_t'(cfg_index))
          kabf_pkg::REG_Q_ANGLE: q_angle_r <= cfg_wdata;
          kabf_pkg::REG_Q_BIAS:  q_bias_r  <= cfg_wdata;
          kabf_pkg::REG_R_MEAS:  r_meas_r  <= cfg_wdata;
          kabf_pkg::REG_DT:      dt_r      <= cfg_wdata;
          default:               dt_r      <= dt_r;
        endcase
      end
      if (mul_rsp.done) begin
        case (st_r)
          kabf_pkg::ST_RATE: ang_r <= kabf_pkg::sat48(51'(ang_r) + 51'(mul_rsp.res));
          kabf_pkg::ST_P11DT: begin
            p01_r <= kabf_pkg::sat48(51'(p01_r) - 51'(mul_rsp.res));
            p10_r <= kabf_pkg::sat48(51'(p10_r) - 51'(mul_rsp.res));
          end
          kabf_pkg::ST_TDT: p00_r <= kabf_pkg::sat48(51'(p00_r) + 51'(mul_rsp.res));
          kabf_pkg::ST_QB:  p11_r <= kabf_pkg::sat48(51'(p11_r) + 51'(mul_rsp.res));
          kabf_pkg::ST_AY:  ang_r <= kabf_pkg::sat48(51'(ang_r) + 51'(mul_rsp.res));
          kabf_pkg::ST_BY:  bias_r <= kabf_pkg::sat48(51'(bias_r) + 51'(mul_rsp.res));
          kabf_pkg::ST_P10: p10_r <= kabf_pkg::sat48(51'(p10_r) - 51'(mul_rsp.res));
          kabf_pkg::ST_P00: p00_r <= kabf_pkg::sat48(51'(p00_r) - 51'(mul_rsp.res));
          kabf_pkg::ST_P11: p11_r <= kabf_pkg::sat48(51'(p11_r) - 51'(mul_rsp.res));
          kabf_pkg::ST_P01: p01_r <= kabf_pkg::sat48(51'(p01_r) - 51'(mul_rsp.res));
          default:          ang_r <= ang_r;
        endcase
      end
    end
  end

  // Working values of the current update.
  always_ff @(posedge clk) begin
    if (accept) begin
      meas_r <= $signed(in_measured_angle);
      diff_r <= kabf_pkg::sat48(51'($signed(in_gyro_rate)) - 51'(bias_r));
    end
    if (mul_rsp.done && (st_r == kabf_pkg::ST_P11DT)) begin
      t_r <= kabf_pkg::sat48(t_sum);
    end
    if (st_r == kabf_pkg::ST_GAIN) begin
      s_r  <= s_nxt;
      y_r  <= kabf_pkg::sat48(51'(meas_r) - 51'(ang_r));
      k0_r <= '0;
      k1_r <= '0;
    end
    if (div_rsp.done && (st_r == kabf_pkg::ST_K0)) begin
      k0_r <= div_rsp.res;
    end
    if (div_rsp.done && (st_r == kabf_pkg::ST_K1)) begin
      k1_r <= div_rsp.res;
    end
    if (fin_load) begin
      fused_r <= ang_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filt_angle = fused_r;

  // An accepted beat keeps the input side closed on the next cycle.
  `KABF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // The two shared units never finish in the same cycle.
  `KABF_ASSERT_IMP(a_one_unit_done, mul_rsp.done, !div_rsp.done)
  // A new result appears only as the sequencer returns to idle.
  `KABF_ASSERT_IMP(a_result_at_idle, $rose(out_valid_r), st_r == kabf_pkg::ST_IDLE)

endmodule
